[rtl/assert_macros.svh]
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/imuc_pkg.sv]
`default_nettype none

package imuc_pkg;

    localparam int unsigned AXES                = 6;
    localparam int unsigned IN_W                = 16;
    localparam int unsigned FRACTION_BITS       = 8;
    localparam int unsigned OFF_W               = IN_W + FRACTION_BITS;
    localparam int unsigned OUT_W               = OFF_W + 1;
    localparam int unsigned DIFF_W              = OUT_W + 1;
    localparam int unsigned CCOUNT_W            = 11;
    localparam int unsigned ALPHA_W             = 17;
    localparam int unsigned PROD_W              = DIFF_W + ALPHA_W + 1;
    localparam int unsigned SMOOTH_SHIFT        = 16;
    localparam int unsigned CFG_IDX_W           = 2;
    localparam int unsigned CFG_DATA_W          = 17;
    localparam int unsigned MAX_CAL_SAMPLES_DEF = 1024;

    localparam logic [CCOUNT_W-1:0] CAL_COUNT_RST = 11'd100;
    localparam logic [ALPHA_W-1:0]  SMOOTH_RST    = 17'd6554;
    localparam logic [ALPHA_W-1:0]  SMOOTH_ONE    = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_COUNT = 2'd0,
        REG_SMOOTHING = 2'd1
    } cfg_reg_t;

    typedef logic signed [IN_W-1:0]  raw_t;
    typedef logic signed [OUT_W-1:0] smooth_t;

    typedef struct packed {
        logic acc;
        logic div_load;
        logic div_step;
        logic div_fin;
        logic filt_load;
        logic mul;
        logic upd;
        logic first;
    } imuc_lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/imuc_lane.sv]
`default_nettype none

module imuc_lane #(
    parameter int unsigned MAX_CAL_SAMPLES = imuc_pkg::MAX_CAL_SAMPLES_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire imuc_pkg::imuc_lane_ctrl_t                ctrl,
    input  wire imuc_pkg::raw_t                           raw,
    input  wire logic [$clog2(MAX_CAL_SAMPLES + 1)-1:0]   divisor,
    input  wire logic [imuc_pkg::ALPHA_W-1:0]             alpha,
    output imuc_pkg::smooth_t                             smoothed
);
    import imuc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int unsigned SUM_W = IN_W + $clog2(MAX_CAL_SAMPLES);
    localparam int unsigned DVD_W = SUM_W + FRACTION_BITS;

    logic signed [SUM_W-1:0]  sum_reg,    sum_next;
    logic signed [OFF_W-1:0]  offset_reg, offset_next;
    logic signed [OUT_W-1:0]  filt_reg,   filt_next;
    logic signed [OUT_W-1:0]  curr_reg,   curr_next;
    logic signed [DIFF_W-1:0] diff_reg,   diff_next;
    logic signed [PROD_W-1:0] prod_reg,   prod_next;
    logic [CNT_W-1:0]         rem_reg,    rem_next;
    logic [DVD_W-1:0]         dvd_reg,    dvd_next;
    logic [OFF_W-1:0]         quo_reg,    quo_next;
    logic                     neg_reg,    neg_next;

    logic [SUM_W-1:0]   sum_mag;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     trial_sub;
    logic               trial_ge;
    logic signed [OUT_W-1:0] curr_now;
    logic signed [OUT_W-1:0] step;

    assign curr_now  = OUT_W'($signed({raw, {FRACTION_BITS{1'b0}}})) - OUT_W'(offset_reg);
    assign step      = $signed(prod_reg[SMOOTH_SHIFT +: OUT_W]);
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb begin
        sum_next    = sum_reg;
        offset_next = offset_reg;
        filt_next   = filt_reg;
        curr_next   = curr_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        if (ctrl.acc) begin
            sum_next = sum_reg + SUM_W'(raw);
        end
        // restoring divide of |sum|*2^frac by the sample count, one bit a cycle
        if (ctrl.div_load) begin
            neg_next = sum_reg[SUM_W-1];
            dvd_next = {sum_mag, {FRACTION_BITS{1'b0}}};
            rem_next = '0;
            quo_next = '0;
        end
        if (ctrl.div_step) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[OFF_W-2:0], trial_ge};
            rem_next = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        end
        if (ctrl.div_fin) begin
            offset_next = neg_reg ? $signed(OFF_W'(-quo_reg)) : $signed(quo_reg);
        end
        if (ctrl.filt_load) begin
            curr_next = curr_now;
            diff_next = DIFF_W'(curr_now) - DIFF_W'(filt_reg);
        end
        if (ctrl.mul) begin
            prod_next = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, alpha}));
        end
        if (ctrl.upd) begin
            filt_next = ctrl.first ? curr_reg : filt_reg + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            offset_reg <= '0;
            filt_reg   <= '0;
        end else begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
            filt_reg   <= filt_next;
        end
    end

    always_ff @(posedge aclk) begin
        curr_reg <= curr_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
    end

    assign smoothed = filt_reg;

endmodule

`default_nettype wire

[rtl/imuc_merge.sv]
`default_nettype none

module imuc_merge (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire imuc_pkg::smooth_t lane_val [imuc_pkg::AXES],
    output logic                   load_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output imuc_pkg::smooth_t      m_item [imuc_pkg::AXES]
);
    import imuc_pkg::*;

    logic    valid_reg, valid_next;
    smooth_t item_reg [AXES];

    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // gather all lanes into one result item
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < AXES; i++) begin
                item_reg[i] <= lane_val[i];
            end
        end
    end

    assign m_valid = valid_reg;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            m_item[i] = item_reg[i];
        end
    end

endmodule

`default_nettype wire

[rtl/imu_offset_calibrate_ema_filter_core.sv]
// imu offset calibration and exponential moving average filter
// input channel s_*: one item carries six signed 16-bit axis words (accel x/y/z, gyro x/y/z)
// result channel m_*: six signed 25-bit smoothed axis values in Q8 raw units
// config port: cfg_wr_en, cfg_index, cfg_data; 0 = calibration count, 1 = smoothing factor
// the first calibration_count items (0 taken as 1, capped at MAX_CAL_SAMPLES) are summed per
// axis and give no result; after the last one a bit-serial offset divide runs in every axis
// lane, through DIV_LOAD, DIV and DIV_FIN, before the next item is taken
// after calibration every item gives one result through the lane sequence of difference,
// multiply, update and output load; the next item is taken only after the output load,
// and the result is then shown from the output register
// the output register holds a result while the receiver stalls; the lanes go on with
// the next item and wait only to load the output register again
// reset (aresetn, synchronous, active low) clears sums, offsets, filter state and the
// sample counter and restores the register defaults
`default_nettype none
`include "assert_macros.svh"

module imu_offset_calibrate_ema_filter_core #(
    parameter int unsigned MAX_CAL_SAMPLES = imuc_pkg::MAX_CAL_SAMPLES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_accel_x_raw,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_accel_y_raw,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_accel_z_raw,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_gyro_x_raw,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_gyro_y_raw,
    input  wire logic signed [imuc_pkg::IN_W-1:0]  s_gyro_z_raw,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_accel_x_smoothed,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_accel_y_smoothed,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_accel_z_smoothed,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_gyro_x_smoothed,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_gyro_y_smoothed,
    output logic signed [imuc_pkg::OUT_W-1:0]      m_gyro_z_smoothed,
    input  wire logic                              cfg_wr_en,
    input  wire logic [imuc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [imuc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import imuc_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int unsigned SUM_W  = IN_W + $clog2(MAX_CAL_SAMPLES);
    localparam int unsigned DVD_W  = SUM_W + FRACTION_BITS;
    localparam int unsigned ITER_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_CAL_SAMPLES);
    localparam logic [ITER_W-1:0] ITER_TOP = ITER_W'(DVD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_PUSH,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_FIN
    } state_t;

    state_t              state_reg;
    logic                calibrated_reg;
    logic                awaiting_first_reg;
    logic [CNT_W-1:0]    samples_seen_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [CCOUNT_W-1:0] cal_count_reg;
    logic [ALPHA_W-1:0]  smooth_reg;

    logic                s_fire;
    logic [CNT_W-1:0]    eff_count;
    logic [CNT_W-1:0]    seen_inc;
    logic [ALPHA_W-1:0]  alpha_eff;
    logic                merge_ready;
    logic                merge_load;
    imuc_lane_ctrl_t     lane_ctrl;
    raw_t                raw_vec  [AXES];
    smooth_t             lane_out [AXES];
    smooth_t             out_vec  [AXES];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign seen_inc = samples_seen_reg + 1'b1;

    always_comb begin
        if (cal_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(cal_count_reg) > 32'(MAX_CAL_SAMPLES)) begin
            eff_count = MAX_CNT;
        end else begin
            eff_count = CNT_W'(cal_count_reg);
        end
    end

    assign alpha_eff = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg <= CAL_COUNT_RST;
            smooth_reg    <= SMOOTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAL_COUNT: cal_count_reg <= cfg_data[CCOUNT_W-1:0];
                REG_SMOOTHING: smooth_reg    <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            calibrated_reg     <= 1'b0;
            awaiting_first_reg <= 1'b1;
            samples_seen_reg   <= '0;
            iter_reg           <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!calibrated_reg) begin
                            samples_seen_reg <= seen_inc;
                            if (seen_inc >= eff_count) begin
                                state_reg <= ST_DIV_LOAD;
                            end
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DIV_LOAD: begin
                    iter_reg  <= ITER_TOP;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (iter_reg == '0) begin
                        state_reg <= ST_DIV_FIN;
                    end else begin
                        iter_reg <= iter_reg - 1'b1;
                    end
                end
                ST_DIV_FIN: begin
                    calibrated_reg <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                ST_MUL: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    awaiting_first_reg <= 1'b0;
                    state_reg          <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (merge_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        lane_ctrl.acc       = s_fire && !calibrated_reg;
        lane_ctrl.div_load  = (state_reg == ST_DIV_LOAD);
        lane_ctrl.div_step  = (state_reg == ST_DIV);
        lane_ctrl.div_fin   = (state_reg == ST_DIV_FIN);
        lane_ctrl.filt_load = s_fire && calibrated_reg;
        lane_ctrl.mul       = (state_reg == ST_MUL);
        lane_ctrl.upd       = (state_reg == ST_UPD);
        lane_ctrl.first     = awaiting_first_reg;
    end

    assign merge_load = (state_reg == ST_PUSH) && merge_ready;

    assign raw_vec[0] = s_accel_x_raw;
    assign raw_vec[1] = s_accel_y_raw;
    assign raw_vec[2] = s_accel_z_raw;
    assign raw_vec[3] = s_gyro_x_raw;
    assign raw_vec[4] = s_gyro_y_raw;
    assign raw_vec[5] = s_gyro_z_raw;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        imuc_lane #(
            .MAX_CAL_SAMPLES(MAX_CAL_SAMPLES)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .raw      (raw_vec[g]),
            .divisor  (samples_seen_reg),
            .alpha    (alpha_eff),
            .smoothed (lane_out[g])
        );
    end

    imuc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (merge_load),
        .lane_val   (lane_out),
        .load_ready (merge_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (out_vec)
    );

    assign m_accel_x_smoothed = out_vec[0];
    assign m_accel_y_smoothed = out_vec[1];
    assign m_accel_z_smoothed = out_vec[2];
    assign m_gyro_x_smoothed  = out_vec[3];
    assign m_gyro_y_smoothed  = out_vec[4];
    assign m_gyro_z_smoothed  = out_vec[5];

    `ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_fire && calibrated_reg, !s_ready)
    `ASSERT_NOW(a_result_after_cal, aclk, aresetn, $rose(m_valid), calibrated_reg && !awaiting_first_reg)
    `ASSERT_NOW(a_divisor_nonzero, aclk, aresetn, state_reg == ST_DIV, samples_seen_reg != '0)

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import imuc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int SETTLE      = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int DIR_ROWS    = 25;
    localparam int MAX_GAP     = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [0:AXES-1][IN_W-1:0]  sample_t;
    typedef logic [0:AXES-1][OUT_W-1:0] result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        sample_t                 smp;
        bit                      chk;
        result_t                 res;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sample_t               tx_smp    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    smooth_t               m_accel_x_smoothed, m_accel_y_smoothed, m_accel_z_smoothed;
    smooth_t               m_gyro_x_smoothed, m_gyro_y_smoothed, m_gyro_z_smoothed;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    result_t rx_res;
    assign rx_res = {m_accel_x_smoothed, m_accel_y_smoothed, m_accel_z_smoothed,
                     m_gyro_x_smoothed, m_gyro_y_smoothed, m_gyro_z_smoothed};

    // predictor state
    logic [CCOUNT_W-1:0] cal_count    = CAL_COUNT_RST;
    logic [ALPHA_W-1:0]  smooth_alpha = SMOOTH_RST;
    int                  cal_seen     = 0;
    bit                  calibrated   = 1'b0;
    bit                  filt_loaded  = 1'b0;
    longint              cal_sums   [AXES] = '{default: 0};
    longint              axis_offs  [AXES] = '{default: 0};
    longint              filt_state [AXES] = '{default: 0};

    result_t smoothed_q [$];
    int      err_cnt   = 0;
    int      cycle_cnt = 0;
    bit      tx_burst  = 1'b0;
    bit      rx_burst  = 1'b0;

    string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z",
                                "gyro_x", "gyro_y", "gyro_z"};

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_WRITE,  REG_CAL_COUNT, 17'd2047, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                               16'sd1, -16'sd1}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                               16'sd0, 16'sd0}, 1'b0, '0},
        // count dropped below samples taken, calibration closes on the next item
        '{ROW_WRITE,  REG_CAL_COUNT, 17'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd0, 16'sd2, 16'sd32767, -16'sd32768,
                               16'sd0, 16'sd0}, 1'b0, '0},
        '{ROW_WRITE,  REG_CAL_COUNT, 17'd1024, '0, 1'b0, '0},
        // first load, offsets -85 85 max min 85 -85
        '{ROW_SAMPLE, '0, '0, {16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0},
          1'b1, {25'sd85, -25'sd85, -25'sd16776960, 25'sd16776960, -25'sd85, 25'sd85}},
        '{ROW_SAMPLE, '0, '0, {16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                               16'sd1, -16'sd1}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                               -16'sd1, 16'sd1}, 1'b0, '0},
        '{ROW_WRITE,  REG_SMOOTHING, 17'd65536, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                               16'sd1, -16'sd1},
          1'b1, {25'sd8388437, -25'sd8388693, 25'sd0, 25'sd0, 25'sd171, -25'sd171}},
        // zero weight holds the filter
        '{ROW_WRITE,  REG_SMOOTHING, 17'd0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                               -16'sd1, 16'sd1},
          1'b1, {25'sd8388437, -25'sd8388693, 25'sd0, 25'sd0, 25'sd171, -25'sd171}},
        '{ROW_WRITE,  REG_SMOOTHING, 17'd131071, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                               -16'sd1, 16'sd1},
          1'b1, {-25'sd8388523, 25'sd8388267, -25'sd16776960, 25'sd16776960,
                 -25'sd341, 25'sd341}},
        '{ROW_WRITE,  REG_SMOOTHING, 17'd1, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                               16'sd32767, 16'sd32767}, 1'b0, '0},
        '{ROW_WRITE,  REG_SPARE_A, 17'h1FFFF, '0, 1'b0, '0},
        '{ROW_WRITE,  REG_SPARE_B, 17'h00000, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd12345, -16'sd12345, 16'sd21845, -16'sd21846,
                               16'sd255, -16'sd256}, 1'b0, '0},
        '{ROW_WRITE,  REG_SMOOTHING, 17'd65535, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                               -16'sd32768, -16'sd32768}, 1'b0, '0},
        '{ROW_WRITE,  REG_SMOOTHING, SMOOTH_RST, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, {16'sd1, -16'sd1, 16'sd256, -16'sd256,
                               16'sd4096, -16'sd4096}, 1'b0, '0}
    };

    imu_offset_calibrate_ema_filter_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_accel_x_raw      (tx_smp[0]),
        .s_accel_y_raw      (tx_smp[1]),
        .s_accel_z_raw      (tx_smp[2]),
        .s_gyro_x_raw       (tx_smp[3]),
        .s_gyro_y_raw       (tx_smp[4]),
        .s_gyro_z_raw       (tx_smp[5]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accel_x_smoothed (m_accel_x_smoothed),
        .m_accel_y_smoothed (m_accel_y_smoothed),
        .m_accel_z_smoothed (m_accel_z_smoothed),
        .m_gyro_x_smoothed  (m_gyro_x_smoothed),
        .m_gyro_y_smoothed  (m_gyro_y_smoothed),
        .m_gyro_z_smoothed  (m_gyro_z_smoothed),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("imu_offset_calibrate_ema_filter_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // calibration sums then offset-corrected ema, returns 1 when a result is due
    function automatic bit smooth_predict(input sample_t smp, output result_t res);
        int     lim;
        longint alpha;
        longint curr;
        res = '0;
        if (!calibrated) begin
            for (int i = 0; i < AXES; i++)
                cal_sums[i] += longint'($signed(smp[i]));
            cal_seen++;
            lim = (cal_count == 0) ? 1 :
                  (cal_count > MAX_CAL_SAMPLES_DEF) ? MAX_CAL_SAMPLES_DEF : int'(cal_count);
            if (cal_seen >= lim) begin
                for (int i = 0; i < AXES; i++)
                    axis_offs[i] = (cal_sums[i] * (longint'(1) << FRACTION_BITS))
                                   / longint'(cal_seen);
                calibrated = 1'b1;
            end
            return 1'b0;
        end
        alpha = (smooth_alpha > SMOOTH_ONE) ? longint'(SMOOTH_ONE) : longint'(smooth_alpha);
        for (int i = 0; i < AXES; i++) begin
            curr = longint'($signed(smp[i])) * (longint'(1) << FRACTION_BITS) - axis_offs[i];
            if (!filt_loaded)
                filt_state[i] = curr;
            else
                filt_state[i] += (alpha * (curr - filt_state[i])) >>> SMOOTH_SHIFT;
            res[i] = filt_state[i][OUT_W-1:0];
        end
        filt_loaded = 1'b1;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CAL_COUNT: cal_count    = val[CCOUNT_W-1:0];
            REG_SMOOTHING: smooth_alpha = val[ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input sample_t smp, input bit chk, input result_t typed);
        int      gap;
        bit      have;
        result_t pred;
        if ($urandom_range(0, 29) == 0)
            tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        tx_smp  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        have = smooth_predict(smp, pred);
        if (have || chk)
            smoothed_q.push_back(chk ? typed : pred);
    endtask

    initial begin
        int      stall;
        result_t want;
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid === 1'b1)) @(posedge aclk);
            if (smoothed_q.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = smoothed_q.pop_front();
                for (int i = 0; i < AXES; i++)
                    if (rx_res[i] !== want[i])
                        report_mismatch($sformatf("%s got %0d expected %0d", axis_name[i],
                                                  $signed(rx_res[i]), $signed(want[i])));
            end
        end
    end

    initial begin
        sample_t               smp;
        logic [CFG_DATA_W-1:0] alpha_val;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_WRITE)
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            else
                send_sample(dir_tab[r].smp, dir_tab[r].chk, dir_tab[r].res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       alpha_val = 17'd0;
                1:       alpha_val = 17'd1;
                2:       alpha_val = 17'd65535;
                3:       alpha_val = 17'd65536;
                4:       alpha_val = 17'($urandom_range(65537, 131071));
                default: alpha_val = 17'($urandom_range(1, 65535));
            endcase
            write_reg(REG_SMOOTHING, alpha_val);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_CAL_COUNT, 17'($urandom_range(0, 2047)));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          17'($urandom_range(0, 131071)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                for (int i = 0; i < AXES; i++) begin
                    case ($urandom_range(0, 3))
                        0: smp[i] = 16'($urandom());
                        1: case ($urandom_range(0, 3))
                               0: smp[i] = 16'h7FFF;
                               1: smp[i] = 16'h8000;
                               2: smp[i] = 16'h0000;
                               default: smp[i] = 16'hFFFF;
                           endcase
                        default: smp[i] = 16'($urandom_range(0, 512)) - 16'd256;
                    endcase
                end
                send_sample(smp, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (err_cnt == 0)
            $display("imu_offset_calibrate_ema_filter_core test passed");
        else
            $display("imu_offset_calibrate_ema_filter_core test failed");
        $finish;
    end

endmodule

[imu_offset_calibrate_ema_filter_core.f]
+incdir+rtl
rtl/imuc_pkg.sv
rtl/imuc_lane.sv
rtl/imuc_merge.sv
rtl/imu_offset_calibrate_ema_filter_core.sv
verif/tb_top.sv
